// ===== rtl/core/mfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfpd_pkg
// Shared types and constants for the marker framed pixel deframer.
// ----------------------------------------------------------------------------
package mfpd_pkg;

  localparam int unsigned SideW  = 12;
  localparam int unsigned CountW = 23;

  // Frame marker, in stream order
  localparam logic [7:0] MARKER [4] = '{8'h46, 8'h52, 8'h41, 8'h4D};

  localparam logic [SideW-1:0] MAX_SIDE_RESET = 12'd2048;

  // One pixel transaction on the output side
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [SideW-1:0] frame_width;
    logic [SideW-1:0] frame_height;
    logic             first_pixel;
    logic             last_pixel;
  } mfpd_pix_t;

  // Advance the marker match by one byte; a value of 4 means a full match
  function automatic logic [2:0] hunt_step(input logic [1:0] matched,
                                           input logic [7:0] data);
    logic [2:0] nxt;
    if (data == MARKER[matched]) begin
      nxt = {1'b0, matched} + 3'd1;
    end else if (data == MARKER[0]) begin
      nxt = 3'd1;
    end else begin
      nxt = 3'd0;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/marker_framed_pixel_deframer.sv =====
// ----------------------------------------------------------------------------
// marker_framed_pixel_deframer
// Finds FRAM headers in a byte stream and emits the frame's RGB pixels.
// ----------------------------------------------------------------------------
// Throughput: one input byte per clock, with no stall while the sink is ready.
// Output: a pixel is presented in the cycle after its third byte is accepted,
//   held in the single result register.
// Reset: asynchronous, active low; hunts for a marker, max side is 2048.
// ----------------------------------------------------------------------------
module marker_framed_pixel_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_max_side_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [11:0] frame_width_o,
  output logic [11:0] frame_height_o,
  output logic        first_pixel_o,
  output logic        last_pixel_o
);
  import mfpd_pkg::*;

  logic      acc;
  logic      pix_valid;
  mfpd_pix_t pix;
  mfpd_pix_t pix_out;

  // Accept a byte whenever the result slot can take one
  assign acc = in_valid_i && in_ready_o;

  mfpd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_max_side_i (cfg_max_side_i),
    .acc_i          (acc),
    .in_byte_i      (in_byte_i),
    .pix_valid_o    (pix_valid),
    .pix_o          (pix)
  );

  mfpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (pix_valid),
    .pix_i       (pix),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .take_ok_o   (in_ready_o),
    .pix_o       (pix_out)
  );

  // Drive result fields
  assign red_o          = pix_out.red;
  assign green_o        = pix_out.green;
  assign blue_o         = pix_out.blue;
  assign frame_width_o  = pix_out.frame_width;
  assign frame_height_o = pix_out.frame_height;
  assign first_pixel_o  = pix_out.first_pixel;
  assign last_pixel_o   = pix_out.last_pixel;

endmodule

// ===== rtl/core/mfpd_parser.sv =====
// ----------------------------------------------------------------------------
// mfpd_parser
// Byte parser: marker hunt, size header check and pixel assembly.
// ----------------------------------------------------------------------------
module mfpd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_max_side_i,
  input  logic                acc_i,
  input  logic [7:0]          in_byte_i,
  output logic                pix_valid_o,
  output mfpd_pkg::mfpd_pix_t pix_o
);
  import mfpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [1:0]         mark_q, mark_d;
  logic [23:0]        sz_q, sz_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         bip_q, bip_d;
  logic [CountW-1:0]  left_q, left_d;
  logic [CountW-1:0]  total_q, total_d;
  logic [SideW-1:0]   fw_q, fw_d;
  logic [SideW-1:0]   fh_q, fh_d;
  logic [7:0]         red_q, red_d;
  logic [7:0]         green_q, green_d;
  logic [SideW-1:0]   max_side_q;

  logic [15:0]        hdr_w, hdr_h;
  logic               hdr_bad;
  logic [2:0]         m_hunt, m1, m2, m3, m4;
  logic [2*SideW-1:0] area;

  // Header fields as they stand when the last size byte arrives
  assign hdr_w   = sz_q[23:8];
  assign hdr_h   = {sz_q[7:0], in_byte_i};
  assign hdr_bad = (hdr_w == 16'd0) || (hdr_h == 16'd0) ||
                   (hdr_w > {4'd0, max_side_q}) || (hdr_h > {4'd0, max_side_q});
  assign area    = hdr_w[SideW-1:0] * hdr_h[SideW-1:0];

  // Marker match for a live byte and the rescan of a rejected header
  assign m_hunt = hunt_step(mark_q, in_byte_i);
  assign m1     = hunt_step(2'd0, hdr_w[15:8]);
  assign m2     = hunt_step(m1[1:0], hdr_w[7:0]);
  assign m3     = hunt_step(m2[1:0], hdr_h[15:8]);
  assign m4     = hunt_step(m3[1:0], hdr_h[7:0]);

  // Next state per accepted byte
  always_comb begin
    phase_d     = phase_q;
    mark_d      = mark_q;
    sz_d        = sz_q;
    cnt_d       = cnt_q;
    bip_d       = bip_q;
    left_d      = left_q;
    total_d     = total_q;
    fw_d        = fw_q;
    fh_d        = fh_q;
    red_d       = red_q;
    green_d     = green_q;
    pix_valid_o = 1'b0;

    pix_o.red          = red_q;
    pix_o.green        = green_q;
    pix_o.blue         = in_byte_i;
    pix_o.frame_width  = fw_q;
    pix_o.frame_height = fh_q;
    pix_o.first_pixel  = (left_q == total_q);
    pix_o.last_pixel   = (left_q == CountW'(1));

    if (acc_i) begin
      case (phase_q)
        PH_SIZE: begin
          if (cnt_q != 2'd3) begin
            sz_d  = {sz_q[15:0], in_byte_i};
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d = 2'd0;
            if (hdr_bad) begin
              // Rescan the four size bytes for a fresh marker
              if (m4 == 3'd4) begin
                phase_d = PH_SIZE;
                mark_d  = 2'd0;
                sz_d    = '0;
              end else begin
                phase_d = PH_HUNT;
                mark_d  = m4[1:0];
              end
            end else begin
              phase_d = PH_DATA;
              fw_d    = hdr_w[SideW-1:0];
              fh_d    = hdr_h[SideW-1:0];
              total_d = area[CountW-1:0];
              left_d  = area[CountW-1:0];
              bip_d   = 2'd0;
            end
          end
        end
        PH_DATA: begin
          case (bip_q)
            2'd0: begin
              red_d = in_byte_i;
              bip_d = 2'd1;
            end
            2'd1: begin
              green_d = in_byte_i;
              bip_d   = 2'd2;
            end
            2'd2: begin
              pix_valid_o = 1'b1;
              bip_d       = 2'd3;
            end
            default: begin
              // Drop the fourth byte and count the pixel
              bip_d = 2'd0;
              if (left_q > CountW'(1)) begin
                left_d = left_q - CountW'(1);
              end else begin
                left_d  = '0;
                phase_d = PH_HUNT;
                mark_d  = 2'd0;
              end
            end
          endcase
        end
        default: begin
          // Hunt, including the unused phase code
          if (m_hunt == 3'd4) begin
            phase_d = PH_SIZE;
            mark_d  = 2'd0;
            cnt_d   = 2'd0;
            sz_d    = '0;
          end else begin
            phase_d = PH_HUNT;
            mark_d  = m_hunt[1:0];
          end
        end
      endcase
    end
  end

  // Hold parser state and the size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      mark_q     <= 2'd0;
      sz_q       <= '0;
      cnt_q      <= 2'd0;
      bip_q      <= 2'd0;
      left_q     <= '0;
      total_q    <= '0;
      fw_q       <= '0;
      fh_q       <= '0;
      red_q      <= '0;
      green_q    <= '0;
      max_side_q <= MAX_SIDE_RESET;
    end else begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      sz_q    <= sz_d;
      cnt_q   <= cnt_d;
      bip_q   <= bip_d;
      left_q  <= left_d;
      total_q <= total_d;
      fw_q    <= fw_d;
      fh_q    <= fh_d;
      red_q   <= red_d;
      green_q <= green_d;
      if (cfg_we_i) begin
        max_side_q <= cfg_max_side_i;
      end
    end
  end

  // A payload always has pixels outstanding
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != '0)
    else $error("payload phase with no pixels left");

  // Size collection always starts from a cleared marker match
  a_size_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SIZE |-> mark_q == 2'd0)
    else $error("marker match not cleared in size phase");

  // An emitted pixel moves on to its dropped fourth byte
  a_emit_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o |=> (bip_q == 2'd3 && phase_q == PH_DATA))
    else $error("pixel emitted without advancing to fourth byte");

  // An accepted frame header never has a zero width or height
  a_size_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && phase_q == PH_SIZE && cnt_q == 2'd3 && !hdr_bad) |=>
      (fw_q != '0 && fh_q != '0))
    else $error("accepted frame with zero size");

endmodule

// ===== rtl/core/mfpd_out_reg.sv =====
// ----------------------------------------------------------------------------
// mfpd_out_reg
// Result register with valid/ready handshake toward the pixel sink.
// ----------------------------------------------------------------------------
module mfpd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mfpd_pkg::mfpd_pix_t pix_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                take_ok_o,
  output mfpd_pkg::mfpd_pix_t pix_o
);
  import mfpd_pkg::*;

  logic      valid_q;
  mfpd_pix_t pix_q;

  // Free when empty or being drained this cycle
  assign take_ok_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign pix_o       = pix_q;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_q <= pix_i;
    end
  end

endmodule
